FILE: hw/rtl/xtea_pkg.sv
// shared types, constants and helpers for the xtea block cipher modes block
`timescale 1ns / 1ps
`default_nettype none
package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_MODE = 3'd4,
    REG_DEC  = 3'd5,
    REG_IV   = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  typedef enum logic [2:0] {
    OP_ECB_ENC,
    OP_ECB_DEC,
    OP_CBC_ENC,
    OP_CBC_DEC,
    OP_CTR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        restart;
    logic [63:0] blk;
  } item_t;

  typedef logic [3:0][31:0] key_t;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_t;

  function automatic logic [31:0] mix_word(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/xtea_if.sv
// valid/ready channel interfaces for input, output and configuration words
`timescale 1ns / 1ps
`default_nettype none
interface xtea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_low;
  logic [31:0] data_high;
  logic        restart;
  modport source(output valid, data_low, data_high, restart, input ready);
  modport sink(input valid, data_low, data_high, restart, output ready);
endinterface

interface xtea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_low;
  logic [31:0] result_high;
  modport source(output valid, result_low, result_high, input ready);
  modport sink(input valid, result_low, result_high, output ready);
endinterface

interface xtea_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/xtea_front.sv
// front end: accepts input words and classifies them into cipher operations
`timescale 1ns / 1ps
`default_nettype none
module xtea_front
  import xtea_pkg::*;
(
  xtea_in_if.sink din,
  input  logic [1:0] mode,
  input  logic       dec,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  op_t op;

  always_comb begin
    case (mode)
      MODE_CBC: begin
        op = dec ? OP_CBC_DEC : OP_CBC_ENC;
      end
      MODE_CTR: begin
        op = OP_CTR;
      end
      default: begin
        op = dec ? OP_ECB_DEC : OP_ECB_ENC;
      end
    endcase
  end

  assign push_item.op      = op;
  assign push_item.restart = din.restart;
  assign push_item.blk     = {din.data_high, din.data_low};
  assign push_valid        = din.valid;
  assign din.ready         = push_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/xtea_fifo.sv
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none
module xtea_fifo
  import xtea_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/xtea_back.sv
// back end: chaining state, iterative xtea round engine and output register
`timescale 1ns / 1ps
`default_nettype none
module xtea_back
  import xtea_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  key_t        key,
  input  logic [63:0] iv,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  xtea_out_if.source  dout
);

  localparam int RW = $clog2(ROUNDS + 1);
  localparam logic [63:0] SUM_PROD = 64'(XTEA_DELTA) * 64'(ROUNDS);
  localparam logic [31:0] SUM_DEC_INIT = SUM_PROD[31:0];

  back_state_t state;
  back_state_t state_next;
  logic [RW-1:0] rnd;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   sum;
  logic          is_dec;
  logic          cbc_enc;
  logic [63:0]   mask;
  logic [63:0]   chain;
  logic [63:0]   counter;
  logic          out_valid;
  logic [31:0]   out_low;
  logic [31:0]   out_high;

  logic          load;
  logic          finish;
  logic          out_free;
  logic [63:0]   eff_chain;
  logic [63:0]   eff_ctr;
  logic [63:0]   eng_in;
  logic [63:0]   mask_ld;
  logic [63:0]   chain_ld;
  logic [63:0]   ctr_ld;
  logic [31:0]   a_enc, b_enc, s_enc;
  logic [31:0]   a_dec, b_dec, s_dec;
  logic [31:0]   a_next, b_next, sum_next;
  logic [63:0]   res;

  // one full cycle (two half-rounds) per clock
  always_comb begin
    a_enc = a + (mix_word(b) ^ (sum + key[sum[1:0]]));
    s_enc = sum + XTEA_DELTA;
    b_enc = b + (mix_word(a_enc) ^ (s_enc + key[s_enc[12:11]]));
    b_dec = b - (mix_word(a) ^ (sum + key[sum[12:11]]));
    s_dec = sum - XTEA_DELTA;
    a_dec = a - (mix_word(b_dec) ^ (s_dec + key[s_dec[1:0]]));
    a_next   = is_dec ? a_dec : a_enc;
    b_next   = is_dec ? b_dec : b_enc;
    sum_next = is_dec ? s_dec : s_enc;
  end

  // operands for the word being loaded
  always_comb begin
    eff_chain = pop_item.restart ? iv : chain;
    eff_ctr   = pop_item.restart ? iv : counter;
    eng_in    = pop_item.blk;
    mask_ld   = '0;
    chain_ld  = eff_chain;
    ctr_ld    = eff_ctr;
    case (pop_item.op)
      OP_CBC_ENC: begin
        eng_in = pop_item.blk ^ eff_chain;
      end
      OP_CBC_DEC: begin
        mask_ld  = eff_chain;
        chain_ld = pop_item.blk;
      end
      OP_CTR: begin
        eng_in  = eff_ctr;
        mask_ld = pop_item.blk;
        ctr_ld  = eff_ctr + 64'd1;
      end
      default: begin
        eng_in = pop_item.blk;
      end
    endcase
  end

  assign out_free = !out_valid || dout.ready;
  assign res = ((state == BK_HOLD) ? {b, a} : {b_next, a_next}) ^ mask;

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load       = 1'b0;
    finish     = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          load       = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (rnd == '0) begin
          if (out_free) begin
            finish     = 1'b1;
            state_next = BK_IDLE;
          end else begin
            state_next = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a       <= eng_in[31:0];
      b       <= eng_in[63:32];
      sum     <= (pop_item.op == OP_ECB_DEC || pop_item.op == OP_CBC_DEC) ?
                 SUM_DEC_INIT : 32'd0;
      is_dec  <= (pop_item.op == OP_ECB_DEC || pop_item.op == OP_CBC_DEC);
      cbc_enc <= (pop_item.op == OP_CBC_ENC);
      mask    <= mask_ld;
      rnd     <= RW'(ROUNDS - 1);
    end else if (state == BK_RUN) begin
      a   <= a_next;
      b   <= b_next;
      sum <= sum_next;
      if (rnd != '0) begin
        rnd <= rnd - 1'b1;
      end
    end
    if (finish) begin
      out_low  <= res[31:0];
      out_high <= res[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain     <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        chain   <= chain_ld;
        counter <= ctr_ld;
      end else if (finish && cbc_enc) begin
        chain <= res;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dout.valid       = out_valid;
  assign dout.result_low  = out_low;
  assign dout.result_high = out_high;

endmodule
`default_nettype wire

FILE: hw/rtl/xtea_block_cipher_modes.sv
// top level: xtea ecb/cbc/ctr block cipher with configuration registers
//
//   channel  dir  payload                          handshake
//   din      in   data_low, data_high, restart     valid/ready
//   dout     out  result_low, result_high          valid/ready
//   cfg      in   index (3b), data (64b)           valid/ready, ready held high
//
// each word is loaded in idle in the back end, then iterated in run until the round count
// reaches zero; the last round writes the output register, and no new word is taken till then
// a two-entry queue lets din take up to two more words while the engine or dout stalls
// the engine holds a finished word until the output register frees up
// synchronous active-high rst clears config, chain and counter to zero
`timescale 1ns / 1ps
`default_nettype none
module xtea_block_cipher_modes
  import xtea_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  xtea_in_if.sink     din,
  xtea_out_if.source  dout,
  xtea_cfg_if.sink    cfg
);

  key_t        key;
  logic [1:0]  mode;
  logic        dec;
  logic [63:0] iv;

  logic        push_valid;
  logic        push_ready;
  item_t       push_item;
  logic        pop_valid;
  logic        pop_ready;
  item_t       pop_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= '0;
      mode <= MODE_ECB;
      dec  <= 1'b0;
      iv   <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_KEY0: begin
          key[0] <= cfg.data[31:0];
        end
        REG_KEY1: begin
          key[1] <= cfg.data[31:0];
        end
        REG_KEY2: begin
          key[2] <= cfg.data[31:0];
        end
        REG_KEY3: begin
          key[3] <= cfg.data[31:0];
        end
        REG_MODE: begin
          mode <= cfg.data[1:0];
        end
        REG_DEC: begin
          dec <= cfg.data[0];
        end
        REG_IV: begin
          iv <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  xtea_front u_front (
    .din        (din),
    .mode       (mode),
    .dec        (dec),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  xtea_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  xtea_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .iv        (iv),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .dout      (dout)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/xtea_checker.sv
// port-level checker for the xtea block cipher modes top level
`timescale 1ns / 1ps
`default_nettype none
module xtea_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_low,
  input logic [31:0] out_high
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken on din but not yet delivered on dout
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("output word without a pending input word");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more words in flight than queue, engine and output hold");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_low) && $stable(out_high))
    else $error("stalled output word changed or dropped");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind xtea_block_cipher_modes xtea_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_low   (dout.result_low),
  .out_high  (dout.result_high)
);
`default_nettype wire

FILE: test/tb_xtea_block_cipher_modes.sv
// testbench for the xtea ecb/cbc/ctr block cipher: random and directed words with a scoreboard
`timescale 1ns / 1ps
module tb_xtea_block_cipher_modes;
  import xtea_pkg::*;

  localparam int ROUNDS = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 900;
  localparam int QUIET_AFTER = 750;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  class block_scoreboard;
    logic [31:0] key [4];
    logic [1:0]  mode;
    logic        dec;
    logic [63:0] iv;
    logic [63:0] chain;
    logic [63:0] counter;
    logic [63:0] expected_blocks [$];
    int          errors;

    function new();
      for (int i = 0; i < 4; i++) key[i] = '0;
      mode = MODE_ECB;
      dec = 1'b0;
      iv = '0;
      chain = '0;
      counter = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key[idx[1:0]] = val[31:0];
        REG_MODE: mode = val[1:0];
        REG_DEC: dec = val[0];
        REG_IV: iv = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] feistel_mix(logic [31:0] x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function logic [63:0] encipher(logic [63:0] blk);
      logic [31:0] a, b, s;
      int i;
      a = blk[31:0];
      b = blk[63:32];
      s = '0;
      for (i = 0; i < ROUNDS; i++) begin
        a = a + (feistel_mix(b) ^ (s + key[s[1:0]]));
        s = s + XTEA_DELTA;
        b = b + (feistel_mix(a) ^ (s + key[s[12:11]]));
      end
      return {b, a};
    endfunction

    function logic [63:0] decipher(logic [63:0] blk);
      logic [31:0] a, b, s;
      int i;
      a = blk[31:0];
      b = blk[63:32];
      s = 32'(XTEA_DELTA * ROUNDS);
      for (i = 0; i < ROUNDS; i++) begin
        b = b - (feistel_mix(a) ^ (s + key[s[12:11]]));
        s = s - XTEA_DELTA;
        a = a - (feistel_mix(b) ^ (s + key[s[1:0]]));
      end
      return {b, a};
    endfunction

    function void note_block(logic [31:0] lo, logic [31:0] hi, logic restart);
      logic [63:0] blk, res;
      blk = {hi, lo};
      if (restart) begin
        chain = iv;
        counter = iv;
      end
      case (mode)
        MODE_CBC: begin
          if (dec) begin
            res = decipher(blk) ^ chain;
            chain = blk;
          end else begin
            res = encipher(blk ^ chain);
            chain = res;
          end
        end
        MODE_CTR: begin
          res = blk ^ encipher(counter);
          counter = counter + 64'd1;
        end
        default: res = dec ? decipher(blk) : encipher(blk);
      endcase
      expected_blocks.push_back(res);
    endfunction

    function void check_result(logic [31:0] lo, logic [31:0] hi);
      logic [63:0] exp_blk;
      if (expected_blocks.size() == 0) begin
        $error("result_low: expected none, actual %h (result_high %h)", lo, hi);
        errors++;
        return;
      end
      exp_blk = expected_blocks.pop_front();
      if (lo !== exp_blk[31:0]) begin
        $error("result_low: expected %h, actual %h", exp_blk[31:0], lo);
        errors++;
      end
      if (hi !== exp_blk[63:32]) begin
        $error("result_high: expected %h, actual %h", exp_blk[63:32], hi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int   random_sent;
  int   stuck_cycles;
  block_scoreboard blocks;

  xtea_in_if  din();
  xtea_out_if dout();
  xtea_cfg_if cfg();

  xtea_block_cipher_modes #(.ROUNDS(ROUNDS)) uut (
    .clk(clk),
    .rst(rst),
    .din(din),
    .dout(dout),
    .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink side stalls
  initial begin
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      dout.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) blocks.write_reg(cfg.index, cfg.data);
      if (din.valid && din.ready) blocks.note_block(din.data_low, din.data_high, din.restart);
      if (dout.valid && dout.ready) blocks.check_result(dout.result_low, dout.result_high);
    end
  end

  always @(posedge clk) begin
    if ((cfg.valid && cfg.ready) || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_xtea_block_cipher_modes: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // leaves valid high, the caller lowers it with cfg.valid <= 1'b0 after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic send_block(input logic [31:0] lo, input logic [31:0] hi, input logic restart);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.data_low <= lo;
    din.data_high <= hi;
    din.restart <= restart;
    do @(posedge clk); while (!din.ready);
  endtask

  // stop sending and wait until every expected word is back
  task automatic drain();
    din.valid <= 1'b0;
    do @(posedge clk); while (blocks.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input bit pause_mid);
    logic [63:0] mode_word;
    int k;
    drain();
    idle_on = (random_sent < QUIET_AFTER) ? ($urandom_range(0, 3) != 0) : 1'b0;
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0: write_reg(3'(REG_KEY0 + k), 64'h0);
          1: write_reg(3'(REG_KEY0 + k), '1);
          default: write_reg(3'(REG_KEY0 + k), {$urandom, rand_word()});
        endcase
      end
    end
    mode_word = {$urandom, $urandom};
    mode_word[1:0] = 2'($urandom_range(0, 3));
    write_reg(REG_MODE, mode_word);
    write_reg(REG_DEC, {$urandom, $urandom});
    if ($urandom_range(0, 1) == 1) write_reg(REG_IV, {rand_word(), rand_word()});
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg.valid <= 1'b0;
    for (k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) drain();
      send_block(rand_word(), rand_word(),
                 (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
      random_sent++;
      if (random_sent >= QUIET_AFTER) idle_on = 1'b0;
    end
  endtask

  initial begin
    int phase;
    blocks = new();
    idle_on = 1'b1;
    random_sent = 0;
    rst <= 1'b1;
    din.valid <= 1'b0;
    din.data_low <= '0;
    din.data_high <= '0;
    din.restart <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_KEY0;
    cfg.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero key and ecb encrypt straight out of reset
    send_block(32'h0, 32'h0, 1'b0);
    drain();
    write_reg(REG_KEY0, '1);
    write_reg(REG_KEY1, '1);
    write_reg(REG_KEY2, '1);
    write_reg(REG_KEY3, '1);
    cfg.valid <= 1'b0;
    send_block('1, '1, 1'b0);
    send_block(32'h8000_0000, 32'h0000_0001, 1'b0);
    drain();
    write_reg(REG_KEY1, 64'hFFFF_FFFF_0123_4567);
    write_reg(REG_KEY2, 64'h0);
    write_reg(REG_DEC, '1);
    cfg.valid <= 1'b0;
    send_block(32'h0, 32'h0, 1'b0);
    send_block('1, '1, 1'b0);
    // spare mode code acts as ecb
    drain();
    write_reg(REG_MODE, {62'h3FFF_FFFF_FFFF_FFFF, MODE_SPARE});
    cfg.valid <= 1'b0;
    send_block(32'h1357_9BDF, 32'h2468_ACE0, 1'b1);
    drain();
    write_reg(REG_DEC, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg.valid <= 1'b0;
    send_block(32'hCAFE_F00D, 32'h0BAD_BEEF, 1'b0);
    // cbc with restart, write to an index past the register list
    drain();
    write_reg(REG_UNUSED, '1);
    write_reg(REG_MODE, 64'(MODE_CBC));
    write_reg(REG_IV, 64'hDEAD_BEEF_0F1E_2D3C);
    cfg.valid <= 1'b0;
    send_block(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_block(32'h1111_1111, 32'h2222_2222, 1'b0);
    send_block(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    drain();
    write_reg(REG_DEC, 64'h1);
    cfg.valid <= 1'b0;
    send_block(32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
    send_block(32'h0000_0001, 32'h8000_0000, 1'b0);
    send_block(32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    // new iv alone keeps the chain
    drain();
    write_reg(REG_IV, '1);
    cfg.valid <= 1'b0;
    send_block(32'h3333_3333, 32'h4444_4444, 1'b0);
    // ctr from the top count so it wraps
    drain();
    write_reg(REG_MODE, 64'(MODE_CTR));
    write_reg(REG_DEC, 64'h0);
    cfg.valid <= 1'b0;
    send_block(32'h0, 32'h0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(32'h0123_4567, 32'h89AB_CDEF, 1'b0);
    drain();
    write_reg(REG_DEC, 64'h1);
    cfg.valid <= 1'b0;
    send_block(32'hFEDC_BA98, 32'h7654_3210, 1'b0);
    // ecb leaves chain and count alone
    drain();
    write_reg(REG_MODE, 64'(MODE_ECB));
    cfg.valid <= 1'b0;
    send_block(32'h5555_AAAA, 32'hAAAA_5555, 1'b0);
    drain();
    write_reg(REG_MODE, 64'(MODE_CTR));
    cfg.valid <= 1'b0;
    send_block(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);

    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      random_phase($urandom_range(10, 60), phase == 0 || $urandom_range(0, 3) == 0);
      phase++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (blocks.errors == 0) begin
      $display("tb_xtea_block_cipher_modes: clean");
    end else begin
      $display("tb_xtea_block_cipher_modes: errors");
    end
    $finish;
  end

endmodule
